// ===== rtl/shpal_pkg.sv =====
// Shared types, constants and codes of the shared palette allocator.
`timescale 1ns / 1ps

package shpal_pkg;

   // Store geometry.
   localparam int PALETTES = 4;
   localparam int ENTRIES  = 16;
   localparam int PAL_W    = $clog2(PALETTES);
   localparam int ENT_W    = $clog2(ENTRIES);
   localparam int SLOTS    = PALETTES * ENTRIES;
   localparam int ADDR_W   = $clog2(SLOTS);

   // Beat field widths.
   localparam int TYPE_W   = 3;
   localparam int PNUM_W   = 2;
   localparam int IDX_W    = 4;
   localparam int COLOR_W  = 16;
   localparam int STATUS_W = 3;

   // Reference counts.
   localparam int COUNT_W = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [TYPE_W-1:0] {
      OP_STAGE     = 3'd0,
      OP_INSTALL   = 3'd1,
      OP_READ      = 3'd2,
      OP_SHARED    = 3'd3,
      OP_EXCLUSIVE = 3'd4,
      OP_SPECIFIC  = 3'd5,
      OP_RELEASE   = 3'd6,
      OP_INCREMENT = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_NONE_FREE   = 3'd1,
      ST_UNDERFLOW   = 3'd2,
      ST_EXCL_INC    = 3'd3,
      ST_UNALLOC_INC = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ_WAIT,
      S_INSTALL,
      S_CMP_SELECT,
      S_CMP_SCAN,
      S_CMP_LAST
   } state_type;

   // What the captured request needs after the execute state.
   typedef enum logic [1:0] {
      EX_DONE,
      EX_READ,
      EX_INSTALL,
      EX_COMPARE
   } exec_type;

   // What a shared request does when the current palette does not match.
   typedef enum logic [1:0] {
      MISS_NEXT,
      MISS_INSTALL,
      MISS_FAIL
   } miss_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load_read;
      logic inst_step;
      logic cmp_begin;
      logic cmp_scan;
      logic cmp_skip;
      logic cmp_eval;
   } cmd_type;

   typedef struct packed {
      exec_type exec_kind;
      logic     ent_last;
      logic     q_cand;
      logic     match_now;
      miss_type miss_kind;
   } stat_type;

endpackage

// ===== rtl/shared_palette_allocator.sv =====
// Top level of the shared palette allocator: controller, datapath and checks.
`timescale 1ns / 1ps
// Stage, release and increment requests and refused install, readback, exclusive and
// specific requests finish in the execute state; a readback adds a read wait; install,
// exclusive and specific grants copy the staged words one-word-a-cycle into the palette RAM.
// A shared request skips non-candidate palettes, compares each candidate word by word and,
// if none matches, installs into the lowest free palette or is refused. One item at a time; results never stall.
// Take the next beat in the strobe cycle. Reset clears staging, counts, marks, row flags.

module shared_palette_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [shpal_pkg::TYPE_W-1:0]        req_type,
   input  logic [shpal_pkg::PNUM_W-1:0]        req_palette_number,
   input  logic [shpal_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [shpal_pkg::COLOR_W-1:0]       req_color_word,
   output logic                                rsp_strobe,
   output logic [shpal_pkg::PNUM_W-1:0]        rsp_granted_palette,
   output logic [shpal_pkg::COLOR_W-1:0]       rsp_read_color,
   output logic [shpal_pkg::STATUS_W-1:0]      rsp_status
);

   // Commands from the sequencer and status back from the datapath.
   shpal_pkg::cmd_type  cmd;
   shpal_pkg::stat_type stat;

   // Sequence each request beat: capture, execute, then read wait, copy or compare scan.
   shpal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the stores, counts and marks; decide grants and drive the result fields.
   shpal_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_type),
      .req_palette_number  (req_palette_number),
      .req_entry_index     (req_entry_index),
      .req_color_word      (req_color_word),
      .rsp_granted_palette (rsp_granted_palette),
      .rsp_read_color      (rsp_read_color),
      .rsp_status          (rsp_status)
   );

   // An accepted beat always makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start work");

   // At most one sequencer command at a time.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.exec, cmd.load_read, cmd.inst_step,
                cmd.cmp_begin, cmd.cmp_scan, cmd.cmp_skip, cmd.cmp_eval}))
      else $error("overlapping sequencer commands");

   // One result per beat: strobes never come back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // A refused request always grants the default palette.
   a_refused_default: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == shpal_pkg::ST_NONE_FREE)) |-> (rsp_granted_palette == '0))
      else $error("refused request granted a palette");

endmodule

// ===== rtl/shpal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module shpal_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/shpal_ctrl.sv =====
// Controller state machine of the shared palette allocator.
`timescale 1ns / 1ps

module shpal_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   input  shpal_pkg::stat_type  stat,
   output shpal_pkg::cmd_type   cmd
);

   shpal_pkg::state_type state_ff, state_in;
   logic                 strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= shpal_pkg::S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         shpal_pkg::S_IDLE: begin
            if (start) state_in = shpal_pkg::S_EXEC;
         end
         shpal_pkg::S_EXEC: begin
            case (stat.exec_kind)
               shpal_pkg::EX_READ:    state_in = shpal_pkg::S_READ_WAIT;
               shpal_pkg::EX_INSTALL: state_in = shpal_pkg::S_INSTALL;
               shpal_pkg::EX_COMPARE: state_in = shpal_pkg::S_CMP_SELECT;
               default:               state_in = shpal_pkg::S_IDLE;
            endcase
         end
         shpal_pkg::S_READ_WAIT: state_in = shpal_pkg::S_IDLE;
         shpal_pkg::S_INSTALL: begin
            if (stat.ent_last) state_in = shpal_pkg::S_IDLE;
         end
         shpal_pkg::S_CMP_SELECT: begin
            if (stat.q_cand) begin
               state_in = shpal_pkg::S_CMP_SCAN;
            end else begin
               case (stat.miss_kind)
                  shpal_pkg::MISS_NEXT:    state_in = shpal_pkg::S_CMP_SELECT;
                  shpal_pkg::MISS_INSTALL: state_in = shpal_pkg::S_INSTALL;
                  default:                 state_in = shpal_pkg::S_IDLE;
               endcase
            end
         end
         shpal_pkg::S_CMP_SCAN: begin
            if (stat.ent_last) state_in = shpal_pkg::S_CMP_LAST;
         end
         shpal_pkg::S_CMP_LAST: begin
            if (stat.match_now) begin
               state_in = shpal_pkg::S_IDLE;
            end else begin
               case (stat.miss_kind)
                  shpal_pkg::MISS_NEXT:    state_in = shpal_pkg::S_CMP_SELECT;
                  shpal_pkg::MISS_INSTALL: state_in = shpal_pkg::S_INSTALL;
                  default:                 state_in = shpal_pkg::S_IDLE;
               endcase
            end
         end
         default: state_in = shpal_pkg::S_IDLE;
      endcase
   end

   // Commands and result strobe.
   always_comb begin
      cmd       = '0;
      strobe_in = 1'b0;
      case (state_ff)
         shpal_pkg::S_IDLE: begin
            cmd.capture = start;
         end
         shpal_pkg::S_EXEC: begin
            cmd.exec  = 1'b1;
            strobe_in = (stat.exec_kind == shpal_pkg::EX_DONE);
         end
         shpal_pkg::S_READ_WAIT: begin
            cmd.load_read = 1'b1;
            strobe_in     = 1'b1;
         end
         shpal_pkg::S_INSTALL: begin
            cmd.inst_step = 1'b1;
            strobe_in     = stat.ent_last;
         end
         shpal_pkg::S_CMP_SELECT: begin
            cmd.cmp_begin = stat.q_cand;
            cmd.cmp_skip  = !stat.q_cand;
            strobe_in     = !stat.q_cand && (stat.miss_kind == shpal_pkg::MISS_FAIL);
         end
         shpal_pkg::S_CMP_SCAN: begin
            cmd.cmp_scan = 1'b1;
         end
         shpal_pkg::S_CMP_LAST: begin
            cmd.cmp_eval = 1'b1;
            strobe_in    = stat.match_now || (stat.miss_kind == shpal_pkg::MISS_FAIL);
         end
         default: begin
            cmd       = '0;
            strobe_in = 1'b0;
         end
      endcase
   end

   assign busy       = (state_ff != shpal_pkg::S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== rtl/shpal_datapath.sv =====
// Datapath of the shared palette allocator: stores, counts, scan counters, results.
`timescale 1ns / 1ps

module shpal_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  shpal_pkg::cmd_type               cmd,
   output shpal_pkg::stat_type              stat,
   input  logic [shpal_pkg::TYPE_W-1:0]     req_type,
   input  logic [shpal_pkg::PNUM_W-1:0]     req_palette_number,
   input  logic [shpal_pkg::IDX_W-1:0]      req_entry_index,
   input  logic [shpal_pkg::COLOR_W-1:0]    req_color_word,
   output logic [shpal_pkg::PNUM_W-1:0]     rsp_granted_palette,
   output logic [shpal_pkg::COLOR_W-1:0]    rsp_read_color,
   output logic [shpal_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int P  = shpal_pkg::PALETTES;
   localparam int E  = shpal_pkg::ENTRIES;
   localparam int PW = shpal_pkg::PAL_W;
   localparam int EW = shpal_pkg::ENT_W;
   localparam int AW = shpal_pkg::ADDR_W;
   localparam int CW = shpal_pkg::COLOR_W;
   localparam int NW = shpal_pkg::COUNT_W;

   function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] pal,
                                               input logic [EW-1:0] ent);
      slot_addr = AW'(pal) * AW'(E) + AW'(ent);
   endfunction

   // Captured request.
   shpal_pkg::op_type             op_ff, op_in;
   logic [shpal_pkg::PNUM_W-1:0]  pal_ff, pal_in;
   logic [shpal_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [CW-1:0]                 color_ff, color_in;

   // Allocator state.
   logic [CW-1:0]  staged_ff [E];
   logic [CW-1:0]  staged_in [E];
   logic [NW-1:0]  count_ff [1:P-1];
   logic [NW-1:0]  count_in [1:P-1];
   logic [P-1:1]   excl_ff, excl_in;
   logic [P-1:0]   row_valid_ff, row_valid_in;

   // Sequencing.
   logic [PW-1:0]  tgt_ff, tgt_in;
   logic [EW-1:0]  ent_ff, ent_in;
   logic [PW-1:0]  q_ff, q_in;
   logic           chk_vld_ff, chk_vld_in;
   logic [EW-1:0]  chk_ent_ff, chk_ent_in;
   logic           mism_ff, mism_in;
   logic [PW-1:0]  rd_row_ff, rd_row_in;

   // Result.
   logic [shpal_pkg::PNUM_W-1:0]  res_granted_ff, res_granted_in;
   logic [CW-1:0]                 res_read_ff, res_read_in;
   shpal_pkg::status_type         res_status_ff, res_status_in;

   // Combinational helpers.
   logic           pal_ok, idx_ok, pal_nz, spec_ok;
   logic [PW-1:0]  pal_i;
   logic [EW-1:0]  idx_i;
   logic [P-1:1]   free_vec;
   logic           has_free;
   logic [PW-1:0]  low_free;
   logic           q_last, q_cand;
   logic           chk_diff, match_now, hit, miss;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [CW-1:0]  rd_data, rd_masked;
   shpal_pkg::exec_type exec_kind;
   shpal_pkg::miss_type miss_kind;

   shpal_ram #(
      .WIDTH (CW),
      .DEPTH (shpal_pkg::SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.inst_step),
      .wr_addr (wr_addr),
      .wr_data (staged_ff[ent_ff]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pal_ok = int'(pal_ff) < P;
   assign idx_ok = int'(idx_ff) < E;
   assign pal_i  = PW'(pal_ff);
   assign idx_i  = EW'(idx_ff);
   assign pal_nz = pal_ok && (pal_i != '0);

   always_comb begin
      has_free = 1'b0;
      low_free = '0;
      for (int i = P - 1; i >= 1; i--) begin
         free_vec[i] = (count_ff[i] == '0) && !excl_ff[i];
         if (free_vec[i]) begin
            has_free = 1'b1;
            low_free = PW'(i);
         end
      end
   end

   assign spec_ok = pal_nz && free_vec[pal_i];
   assign q_last  = (q_ff == PW'(P - 1));
   assign q_cand  = (q_ff == '0) ? 1'b1 : ((count_ff[q_ff] != '0) && !excl_ff[q_ff]);

   // Read path shared by readback and compare scan.
   assign rd_row_in = cmd.cmp_scan ? q_ff : pal_i;
   assign rd_addr   = slot_addr(rd_row_in, cmd.cmp_scan ? ent_ff : idx_i);
   assign wr_addr   = slot_addr(tgt_ff, ent_ff);
   assign rd_masked = row_valid_ff[rd_row_ff] ? rd_data : '0;

   assign chk_diff  = chk_vld_ff && (rd_masked != staged_ff[chk_ent_ff]);
   assign match_now = !mism_ff && !chk_diff;
   assign hit       = cmd.cmp_eval && match_now;
   assign miss      = cmd.cmp_skip || (cmd.cmp_eval && !match_now);

   always_comb begin
      case (op_ff)
         shpal_pkg::OP_INSTALL:
            exec_kind = pal_ok ? shpal_pkg::EX_INSTALL : shpal_pkg::EX_DONE;
         shpal_pkg::OP_READ:
            exec_kind = (pal_ok && idx_ok) ? shpal_pkg::EX_READ : shpal_pkg::EX_DONE;
         shpal_pkg::OP_SHARED:
            exec_kind = shpal_pkg::EX_COMPARE;
         shpal_pkg::OP_EXCLUSIVE:
            exec_kind = has_free ? shpal_pkg::EX_INSTALL : shpal_pkg::EX_DONE;
         shpal_pkg::OP_SPECIFIC:
            exec_kind = spec_ok ? shpal_pkg::EX_INSTALL : shpal_pkg::EX_DONE;
         default:
            exec_kind = shpal_pkg::EX_DONE;
      endcase
   end

   always_comb begin
      if (!q_last) begin
         miss_kind = shpal_pkg::MISS_NEXT;
      end else if (has_free) begin
         miss_kind = shpal_pkg::MISS_INSTALL;
      end else begin
         miss_kind = shpal_pkg::MISS_FAIL;
      end
   end

   always_comb begin
      op_in          = op_ff;
      pal_in         = pal_ff;
      idx_in         = idx_ff;
      color_in       = color_ff;
      staged_in      = staged_ff;
      count_in       = count_ff;
      excl_in        = excl_ff;
      row_valid_in   = row_valid_ff;
      tgt_in         = tgt_ff;
      ent_in         = ent_ff;
      q_in           = q_ff;
      chk_vld_in     = chk_vld_ff;
      chk_ent_in     = chk_ent_ff;
      mism_in        = mism_ff;
      res_granted_in = res_granted_ff;
      res_read_in    = res_read_ff;
      res_status_in  = res_status_ff;

      if (cmd.capture) begin
         op_in    = shpal_pkg::op_type'(req_type);
         pal_in   = req_palette_number;
         idx_in   = req_entry_index;
         color_in = req_color_word;
      end

      if (cmd.exec) begin
         res_granted_in = '0;
         res_read_in    = '0;
         res_status_in  = shpal_pkg::ST_OK;
         case (op_ff)
            shpal_pkg::OP_STAGE: begin
               if (idx_ok) staged_in[idx_i] = color_ff;
            end
            shpal_pkg::OP_INSTALL: begin
               if (pal_ok) begin
                  tgt_in              = pal_i;
                  ent_in              = '0;
                  row_valid_in[pal_i] = 1'b1;
               end
            end
            shpal_pkg::OP_SHARED: begin
               q_in = '0;
            end
            shpal_pkg::OP_EXCLUSIVE: begin
               if (has_free) begin
                  excl_in[low_free]      = 1'b1;
                  tgt_in                 = low_free;
                  ent_in                 = '0;
                  row_valid_in[low_free] = 1'b1;
                  res_granted_in         = shpal_pkg::PNUM_W'(low_free);
               end else begin
                  res_status_in = shpal_pkg::ST_NONE_FREE;
               end
            end
            shpal_pkg::OP_SPECIFIC: begin
               if (spec_ok) begin
                  excl_in[pal_i]      = 1'b1;
                  tgt_in              = pal_i;
                  ent_in              = '0;
                  row_valid_in[pal_i] = 1'b1;
                  res_granted_in      = pal_ff;
               end else begin
                  res_status_in = shpal_pkg::ST_NONE_FREE;
               end
            end
            shpal_pkg::OP_RELEASE: begin
               if (pal_nz) begin
                  if (excl_ff[pal_i]) begin
                     excl_in[pal_i]  = 1'b0;
                     count_in[pal_i] = '0;
                  end else if (count_ff[pal_i] == '0) begin
                     res_status_in = shpal_pkg::ST_UNDERFLOW;
                  end else begin
                     count_in[pal_i] = count_ff[pal_i] - 1'b1;
                  end
               end
            end
            shpal_pkg::OP_INCREMENT: begin
               if (pal_nz) begin
                  if (excl_ff[pal_i]) begin
                     res_status_in = shpal_pkg::ST_EXCL_INC;
                  end else begin
                     if (count_ff[pal_i] == '0) res_status_in = shpal_pkg::ST_UNALLOC_INC;
                     if (count_ff[pal_i] != shpal_pkg::COUNT_MAX) begin
                        count_in[pal_i] = count_ff[pal_i] + 1'b1;
                     end
                  end
               end
            end
            default: begin
               res_status_in = shpal_pkg::ST_OK;
            end
         endcase
      end

      if (cmd.load_read) res_read_in = rd_masked;

      if (cmd.inst_step) ent_in = ent_ff + 1'b1;

      if (cmd.cmp_begin) begin
         ent_in     = EW'(1);
         chk_vld_in = 1'b0;
         mism_in    = 1'b0;
      end

      if (cmd.cmp_scan) begin
         ent_in     = ent_ff + 1'b1;
         chk_vld_in = 1'b1;
         chk_ent_in = ent_ff;
         if (chk_diff) mism_in = 1'b1;
      end

      if (hit) begin
         if ((q_ff != '0) && (count_ff[q_ff] != shpal_pkg::COUNT_MAX)) begin
            count_in[q_ff] = count_ff[q_ff] + 1'b1;
         end
         res_granted_in = shpal_pkg::PNUM_W'(q_ff);
      end else if (miss) begin
         case (miss_kind)
            shpal_pkg::MISS_NEXT: begin
               q_in = q_ff + 1'b1;
            end
            shpal_pkg::MISS_INSTALL: begin
               count_in[low_free]     = NW'(1);
               tgt_in                 = low_free;
               ent_in                 = '0;
               row_valid_in[low_free] = 1'b1;
               res_granted_in         = shpal_pkg::PNUM_W'(low_free);
            end
            default: begin
               res_status_in = shpal_pkg::ST_NONE_FREE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < E; i++) staged_ff[i] <= '0;
         for (int i = 1; i < P; i++) count_ff[i] <= '0;
         excl_ff      <= '0;
         row_valid_ff <= '0;
         ent_ff       <= '0;
         q_ff         <= '0;
         chk_vld_ff   <= 1'b0;
         mism_ff      <= 1'b0;
      end else begin
         staged_ff    <= staged_in;
         count_ff     <= count_in;
         excl_ff      <= excl_in;
         row_valid_ff <= row_valid_in;
         ent_ff       <= ent_in;
         q_ff         <= q_in;
         chk_vld_ff   <= chk_vld_in;
         mism_ff      <= mism_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pal_ff         <= pal_in;
      idx_ff         <= idx_in;
      color_ff       <= color_in;
      tgt_ff         <= tgt_in;
      chk_ent_ff     <= chk_ent_in;
      rd_row_ff      <= rd_row_in;
      res_granted_ff <= res_granted_in;
      res_read_ff    <= res_read_in;
      res_status_ff  <= res_status_in;
   end

   assign stat.exec_kind = exec_kind;
   assign stat.ent_last  = (ent_ff == EW'(E - 1));
   assign stat.q_cand    = q_cand;
   assign stat.match_now = match_now;
   assign stat.miss_kind = miss_kind;

   assign rsp_granted_palette = res_granted_ff;
   assign rsp_read_color      = res_read_ff;
   assign rsp_status          = res_status_ff;

endmodule
